@@ rtl/iira_pkg.sv @@
// ----------------------------------------------------------------------------
// iira_pkg: shared types and constants
// Request codes, status codes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package iira_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W      = 3;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_INIT   = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FILL,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_BELOW,
		RD_ABOVE
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_REQ,
		WR_SHIFT,
		WR_FILL
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_LOAD_COUNT,
		IDX_LOAD_POS,
		IDX_LOAD_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_LOAD_INIT
	} cnt_op_t;

	typedef struct packed {
		logic    load_req;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		idx_op_t idx_op;
		cnt_op_t cnt_op;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            req_ok;
		logic            shift_done;
		logic            fill_done;
		logic            out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/iira_ctrl.sv @@
// ----------------------------------------------------------------------------
// iira_ctrl: request sequencer
// Decodes each request and steps the datapath through shift and fill loops.
// ----------------------------------------------------------------------------
`default_nettype none

module iira_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  iira_pkg::sts_t sts,
	output iira_pkg::cmd_t cmd
);
	import iira_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				case (sts.op)
					OP_INSERT, OP_REMOVE: state_nxt = sts.req_ok ? S_SHIFT_RD : S_FINISH;
					OP_INIT:              state_nxt = S_FILL;
					default:              state_nxt = S_FINISH;
				endcase
			end
			S_SHIFT_RD: begin
				state_nxt = sts.shift_done ? S_FINISH : S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				state_nxt = S_SHIFT_RD;
			end
			S_FILL: begin
				if (sts.fill_done) state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.load_req = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.rd_sel   = RD_POS;
		cmd.wr_en    = 1'b0;
		cmd.wr_sel   = WR_REQ;
		cmd.idx_op   = IDX_HOLD;
		cmd.cnt_op   = CNT_HOLD;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			S_DECODE: begin
				case (sts.op)
					OP_READ: begin
						cmd.rd_en  = sts.req_ok;
						cmd.rd_sel = RD_POS;
					end
					OP_WRITE: begin
						cmd.wr_en  = sts.req_ok;
						cmd.wr_sel = WR_REQ;
					end
					OP_INSERT: cmd.idx_op = IDX_LOAD_COUNT;
					OP_REMOVE: cmd.idx_op = IDX_LOAD_POS;
					OP_INIT:   cmd.idx_op = IDX_LOAD_ZERO;
					default: ;
				endcase
			end
			S_SHIFT_RD: begin
				if (sts.shift_done) begin
					if (sts.op == OP_INSERT) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_REQ;
						cmd.cnt_op = CNT_INC;
					end else begin
						cmd.cnt_op = CNT_DEC;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = (sts.op == OP_INSERT) ? RD_BELOW : RD_ABOVE;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.idx_op = (sts.op == OP_INSERT) ? IDX_DEC : IDX_INC;
			end
			S_FILL: begin
				if (sts.fill_done) begin
					cmd.cnt_op = CNT_LOAD_INIT;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_FILL;
					cmd.idx_op = IDX_INC;
				end
			end
			S_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/iira_dp.sv @@
// ----------------------------------------------------------------------------
// iira_dp: list datapath
// Entry memory, live count, walk index, configuration and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iira_dp #(
	parameter int DEPTH      = iira_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int CFG_W = (DATA_WIDTH > CW) ? DATA_WIDTH : CW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [iira_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic [iira_pkg::OP_W-1:0]      op,
	input  logic [CW-1:0]                  position,
	input  logic signed [DATA_WIDTH-1:0]   data_in,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [DATA_WIDTH-1:0]   read_data,
	output logic [CW-1:0]                  count,
	output logic                           empty_res,
	output logic [iira_pkg::ST_W-1:0]      status,
	input  iira_pkg::cmd_t                 cmd,
	output iira_pkg::sts_t                 sts
);
	import iira_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [CW-1:0]         init_count_q;
	logic [DATA_WIDTH-1:0] fill_q;

	logic [OP_W-1:0]       op_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [ST_W-1:0]       status_q;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] fill_len;

	logic [ST_W-1:0]       req_st;
	logic [CW-1:0]         raddr;
	logic [CW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] rd_out_q;
	logic [CW-1:0]         cnt_out_q;
	logic                  empty_q;
	logic [ST_W-1:0]       st_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_count_q <= '0;
			fill_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INIT_COUNT: init_count_q <= cfg_data[CW-1:0];
				CFG_FILL_VALUE: fill_q       <= cfg_data[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (op)
			OP_READ, OP_WRITE, OP_REMOVE: req_st = (position < count_q) ? ST_OK : ST_RANGE;
			OP_INSERT: begin
				if (count_q == DEPTH_C)      req_st = ST_FULL;
				else if (position > count_q) req_st = ST_RANGE;
				else                         req_st = ST_OK;
			end
			default: req_st = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q     <= op;
			pos_q    <= position;
			data_q   <= data_in;
			status_q <= req_st;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			IDX_LOAD_COUNT: idx_q <= count_q;
			IDX_LOAD_POS:   idx_q <= pos_q;
			IDX_LOAD_ZERO:  idx_q <= '0;
			IDX_INC:        idx_q <= idx_q + ONE_C;
			IDX_DEC:        idx_q <= idx_q - ONE_C;
			default: ;
		endcase
	end

	assign fill_len = (init_count_q > DEPTH_C) ? DEPTH_C : init_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC:       count_q <= count_q + ONE_C;
				CNT_DEC:       count_q <= count_q - ONE_C;
				CNT_LOAD_INIT: count_q <= fill_len;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_BELOW: raddr = idx_q - ONE_C;
			RD_ABOVE: raddr = idx_q + ONE_C;
			default:  raddr = pos_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_SHIFT: begin
				waddr = idx_q;
				wdata = rdata_q;
			end
			WR_FILL: begin
				waddr = idx_q;
				wdata = fill_q;
			end
			default: begin
				waddr = pos_q;
				wdata = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem_q[waddr[AW-1:0]] <= wdata;
		if (cmd.rd_en) rdata_q <= mem_q[raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rd_out_q  <= (op_q == OP_READ && status_q == ST_OK) ? rdata_q : '0;
			cnt_out_q <= count_q;
			empty_q   <= (count_q == '0);
			st_out_q  <= status_q;
		end
	end

	assign sts.op         = op_q;
	assign sts.req_ok     = (status_q == ST_OK);
	assign sts.shift_done = (op_q == OP_INSERT) ? (idx_q == pos_q)
	                                            : ((idx_q + ONE_C) == count_q);
	assign sts.fill_done  = (idx_q == fill_len);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign read_data = rd_out_q;
	assign count     = cnt_out_q;
	assign empty_res = empty_q;
	assign status    = st_out_q;

endmodule

`default_nettype wire

@@ rtl/indexed_insert_remove_array.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_array: ordered list with insert and remove by position
// Bounded list of signed entries with a live count, one result per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; the entries sit in a single memory with
// one read and one write port, and every shift or fill step goes through it.
// An insert moves count - position entries and a remove count - 1 - position,
// each moved entry costing one memory read and one memory write, and an
// initialize writes min(initial_count, DEPTH) entries of the fill value. A new
// request is accepted while the last result still waits in the output register.
`default_nettype none

module indexed_insert_remove_array #(
	parameter int DEPTH      = iira_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int CFG_W = (DATA_WIDTH > CW) ? DATA_WIDTH : CW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [iira_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [iira_pkg::OP_W-1:0]      op,
	input  logic [CW-1:0]                  position,
	input  logic signed [DATA_WIDTH-1:0]   data_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [DATA_WIDTH-1:0]   read_data,
	output logic [CW-1:0]                  count,
	output logic                           empty_res,
	output logic [iira_pkg::ST_W-1:0]      status
);
	import iira_pkg::*;

	cmd_t cmd;
	sts_t sts;

	iira_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iira_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op        (op),
		.position  (position),
		.data_in   (data_in),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.read_data (read_data),
		.count     (count),
		.empty_res (empty_res),
		.status    (status),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

@@ rtl/iira_chk.sv @@
// ----------------------------------------------------------------------------
// iira_chk: port-level checks
// Watches the top-level ports for result consistency and request pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module iira_chk #(
	parameter int DEPTH      = iira_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [DATA_WIDTH-1:0]   read_data,
	input logic [CW-1:0]                  count,
	input logic                           empty_res,
	input logic [iira_pkg::ST_W-1:0]      status
);
	import iira_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(count)
			&& $stable(status) && $stable(empty_res))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (empty_res == (count == '0)))
		else $error("empty flag disagrees with count");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= CW'(DEPTH)) && (status <= ST_FULL))
		else $error("count or status out of range");

	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_data == '0)
		else $error("read data on failed request");

	a_pace: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken before previous one finished");

endmodule

bind indexed_insert_remove_array iira_chk #(
	.DEPTH      (DEPTH),
	.DATA_WIDTH (DATA_WIDTH)
) u_chk (.*);

`default_nettype wire
